FILE: src/ptt_pkg.sv
// Shared types, codes and sizes for the periodic task timer table.
`default_nettype none

package ptt_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int IDX_W     = $clog2(NUM_SLOTS);

    localparam int CMD_W     = 4;
    localparam int SLOT_W    = 4;
    localparam int MS_W      = 32;
    localparam int RPT_W     = 16;
    localparam int CNT_W     = 15;
    localparam int EL_W      = 16;
    localparam int STATUS_W  = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK    = 4'd0;
    localparam logic [CMD_W-1:0] CMD_CREATE  = 4'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 4'd2;
    localparam logic [CMD_W-1:0] CMD_PAUSE   = 4'd3;
    localparam logic [CMD_W-1:0] CMD_RESUME  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_READY   = 4'd5;
    localparam logic [CMD_W-1:0] CMD_RST_TIM = 4'd6;
    localparam logic [CMD_W-1:0] CMD_SET_PER = 4'd7;
    localparam logic [CMD_W-1:0] CMD_SET_RPT = 4'd8;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 4'd9;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NACTIVE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADARG  = 2'd3;

    typedef struct packed {
        logic             paused;
        logic [CNT_W-1:0] repeat_cnt;
        logic [MS_W-1:0]  acc;
        logic [MS_W-1:0]  period;
    } slot_entry_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             we;
        logic [IDX_W-1:0] wr_addr;
        slot_entry_t      wr_data;
    } mem_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   result_slot;
        logic                fired;
        logic                finished;
        logic                present;
        logic [RPT_W-1:0]    repeat_value;
        logic [MS_W-1:0]     total;
        logic                last;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t res;
    } push_t;

endpackage

`default_nettype wire

FILE: src/ptt_slot_mem.sv
// Slot store: period, accumulator, repeat count and pause mark per slot.
`default_nettype none

module ptt_slot_mem (
    input  wire logic                aclk,
    input  wire ptt_pkg::mem_req_t   req_i,
    output ptt_pkg::slot_entry_t     rd_data_o
);

    ptt_pkg::slot_entry_t mem [ptt_pkg::NUM_SLOTS];
    ptt_pkg::slot_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req_i.we) begin
            mem[req_i.wr_addr] <= req_i.wr_data;
        end
        if (req_i.rd_en) begin
            rd_data_reg <= mem[req_i.rd_addr];
        end
    end

    assign rd_data_o = rd_data_reg;

endmodule

`default_nettype wire

FILE: src/ptt_ctrl.sv
// Command sequencer: decodes words, sweeps slots on tick, holds active bits.
`default_nettype none

module ptt_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid_i,
    output logic                               in_ready_o,
    input  wire logic [ptt_pkg::CMD_W-1:0]     cmd_i,
    input  wire logic [ptt_pkg::SLOT_W-1:0]    slot_i,
    input  wire logic [ptt_pkg::MS_W-1:0]      period_i,
    input  wire logic [ptt_pkg::RPT_W-1:0]     rpt_i,
    input  wire logic                          clr_i,
    input  wire logic [ptt_pkg::EL_W-1:0]      elapsed_i,
    output ptt_pkg::mem_req_t                  mem_req_o,
    input  wire ptt_pkg::slot_entry_t          rd_data_i,
    input  wire logic                          can_push_i,
    output ptt_pkg::push_t                     push_o
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMD  = 4'b0010,
        S_TICK = 4'b0100,
        S_RESP = 4'b1000
    } state_t;

    state_t                        state_reg, state_next;
    logic [ptt_pkg::CMD_W-1:0]     cmd_reg, cmd_next;
    logic [ptt_pkg::SLOT_W-1:0]    slot_reg, slot_next;
    logic [ptt_pkg::MS_W-1:0]      period_reg, period_next;
    logic [ptt_pkg::RPT_W-1:0]     rpt_reg, rpt_next;
    logic                          clr_reg, clr_next;
    logic [ptt_pkg::EL_W-1:0]      el_reg, el_next;
    logic [ptt_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic [ptt_pkg::NUM_SLOTS-1:0] active_reg, active_next;
    logic [ptt_pkg::MS_W-1:0]      total_reg, total_next;
    ptt_pkg::result_t              res_reg, res_next;
    logic                          pend_reg, pend_next;

    logic                          accept;
    logic [ptt_pkg::IDX_W-1:0]     slot_idx;
    logic                          slot_ok;
    logic                          free_found;
    logic [ptt_pkg::IDX_W-1:0]     free_idx;
    ptt_pkg::slot_entry_t          ent;
    logic                          live;
    logic [ptt_pkg::MS_W-1:0]      sum;
    logic                          fire;
    logic                          stall;
    logic [ptt_pkg::CNT_W-1:0]     rpt_dec;
    logic                          fin;
    ptt_pkg::result_t              empty_res;

    assign in_ready_o = (state_reg == S_IDLE);
    assign accept     = in_valid_i && in_ready_o;
    assign slot_idx   = ptt_pkg::IDX_W'(slot_i);
    assign slot_ok    = (int'(slot_i) < ptt_pkg::NUM_SLOTS) && active_reg[slot_idx];
    assign ent        = rd_data_i;

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = ptt_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
            if (!active_reg[i]) begin
                free_found = 1'b1;
                free_idx   = ptt_pkg::IDX_W'(i);
            end
        end
    end

    // tick evaluation of the slot whose entry is on the read port
    assign live    = active_reg[idx_reg] && !ent.paused;
    assign sum     = ent.acc + ptt_pkg::MS_W'(el_reg);
    assign fire    = live && (sum >= ent.period);
    assign stall   = fire && pend_reg && !can_push_i;
    assign rpt_dec = ent.repeat_cnt - ptt_pkg::CNT_W'(1);
    assign fin     = fire && (ent.repeat_cnt != '0) && (rpt_dec == '0);

    always_comb begin
        empty_res        = '0;
        empty_res.status = ptt_pkg::ST_OK;
        empty_res.last   = 1'b1;
    end

    always_comb begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        slot_next   = slot_reg;
        period_next = period_reg;
        rpt_next    = rpt_reg;
        clr_next    = clr_reg;
        el_next     = el_reg;
        idx_next    = idx_reg;
        active_next = active_reg;
        total_next  = total_reg;
        res_next    = res_reg;
        pend_next   = pend_reg;
        mem_req_o   = '0;
        push_o      = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd_next    = cmd_i;
                    slot_next   = slot_i;
                    period_next = period_i;
                    rpt_next    = rpt_i;
                    clr_next    = clr_i;
                    el_next     = elapsed_i;
                    res_next    = empty_res;
                    state_next  = S_RESP;
                    if (cmd_i == ptt_pkg::CMD_TICK) begin
                        total_next        = total_reg + ptt_pkg::MS_W'(elapsed_i);
                        idx_next          = '0;
                        pend_next         = 1'b0;
                        mem_req_o.rd_en   = 1'b1;
                        mem_req_o.rd_addr = '0;
                        state_next        = S_TICK;
                    end else if (cmd_i == ptt_pkg::CMD_CREATE) begin
                        if (free_found) begin
                            mem_req_o.we                 = 1'b1;
                            mem_req_o.wr_addr            = free_idx;
                            mem_req_o.wr_data.period     = period_i;
                            mem_req_o.wr_data.acc        = '0;
                            mem_req_o.wr_data.paused     = rpt_i[ptt_pkg::RPT_W-1];
                            // negative count: created paused, count stored as -n-1
                            mem_req_o.wr_data.repeat_cnt = rpt_i[ptt_pkg::RPT_W-1]
                                ? ~rpt_i[ptt_pkg::CNT_W-1:0] : rpt_i[ptt_pkg::CNT_W-1:0];
                            active_next[free_idx]        = 1'b1;
                            res_next.result_slot         = ptt_pkg::SLOT_W'(free_idx);
                        end else begin
                            res_next.status = ptt_pkg::ST_FULL;
                        end
                    end else if (cmd_i > ptt_pkg::CMD_QUERY) begin
                        res_next.status      = ptt_pkg::ST_BADARG;
                        res_next.result_slot = slot_i;
                    end else if (!slot_ok) begin
                        res_next.status      = ptt_pkg::ST_NACTIVE;
                        res_next.result_slot = slot_i;
                        if (cmd_i == ptt_pkg::CMD_QUERY) begin
                            res_next.repeat_value = '1;
                        end
                    end else if (cmd_i == ptt_pkg::CMD_DELETE) begin
                        active_next[slot_idx] = 1'b0;
                        res_next.result_slot  = slot_i;
                    end else begin
                        mem_req_o.rd_en   = 1'b1;
                        mem_req_o.rd_addr = slot_idx;
                        state_next        = S_CMD;
                    end
                end
            end

            S_CMD: begin
                mem_req_o.we         = 1'b1;
                mem_req_o.wr_addr    = ptt_pkg::IDX_W'(slot_reg);
                mem_req_o.wr_data    = ent;
                res_next.result_slot = slot_reg;
                state_next           = S_RESP;
                case (cmd_reg)
                    ptt_pkg::CMD_PAUSE:   mem_req_o.wr_data.paused = 1'b1;
                    ptt_pkg::CMD_RESUME:  mem_req_o.wr_data.paused = 1'b0;
                    ptt_pkg::CMD_READY: begin
                        mem_req_o.wr_data.acc = clr_reg ? ent.period : ent.acc + ent.period;
                    end
                    ptt_pkg::CMD_RST_TIM: mem_req_o.wr_data.acc = '0;
                    ptt_pkg::CMD_SET_PER: begin
                        mem_req_o.wr_data.acc    = '0;
                        mem_req_o.wr_data.period = period_reg;
                    end
                    ptt_pkg::CMD_SET_RPT: begin
                        if (rpt_reg[ptt_pkg::RPT_W-1]) begin
                            mem_req_o.we    = 1'b0;
                            res_next.status = ptt_pkg::ST_BADARG;
                        end else begin
                            mem_req_o.wr_data.repeat_cnt = rpt_reg[ptt_pkg::CNT_W-1:0];
                            mem_req_o.wr_data.paused     = 1'b0;
                        end
                    end
                    ptt_pkg::CMD_QUERY: begin
                        mem_req_o.we          = 1'b0;
                        res_next.present      = 1'b1;
                        res_next.repeat_value = ent.paused ? ~{1'b0, ent.repeat_cnt}
                                                           : {1'b0, ent.repeat_cnt};
                    end
                    default: mem_req_o.we = 1'b0;
                endcase
            end

            S_TICK: begin
                if (!stall) begin
                    if (live) begin
                        mem_req_o.we      = 1'b1;
                        mem_req_o.wr_addr = idx_reg;
                        mem_req_o.wr_data = ent;
                        mem_req_o.wr_data.acc = fire ? sum - ent.period : sum;
                        if (fire && ent.repeat_cnt != '0) begin
                            mem_req_o.wr_data.repeat_cnt = rpt_dec;
                        end
                    end
                    if (fin) begin
                        active_next[idx_reg] = 1'b0;
                    end
                    if (fire) begin
                        // the held firing is not the final one: send it with last low
                        push_o.valid         = pend_reg;
                        push_o.res           = res_reg;
                        push_o.res.last      = 1'b0;
                        push_o.res.total     = total_reg;
                        res_next             = empty_res;
                        res_next.result_slot = ptt_pkg::SLOT_W'(idx_reg);
                        res_next.fired       = 1'b1;
                        res_next.finished    = fin;
                        pend_next            = 1'b1;
                    end
                    if (idx_reg == ptt_pkg::IDX_W'(ptt_pkg::NUM_SLOTS - 1)) begin
                        state_next = S_RESP;
                    end else begin
                        idx_next          = idx_reg + ptt_pkg::IDX_W'(1);
                        mem_req_o.rd_en   = 1'b1;
                        mem_req_o.rd_addr = idx_reg + ptt_pkg::IDX_W'(1);
                    end
                end
            end

            S_RESP: begin
                if (can_push_i) begin
                    push_o.valid     = 1'b1;
                    push_o.res       = res_reg;
                    push_o.res.total = total_reg;
                    state_next       = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            active_reg <= '0;
            total_reg  <= '0;
            pend_reg   <= 1'b0;
            idx_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            active_reg <= active_next;
            total_reg  <= total_next;
            pend_reg   <= pend_next;
            idx_reg    <= idx_next;
        end
        cmd_reg    <= cmd_next;
        slot_reg   <= slot_next;
        period_reg <= period_next;
        rpt_reg    <= rpt_next;
        clr_reg    <= clr_next;
        el_reg     <= el_next;
        res_reg    <= res_next;
    end

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push_o.valid |-> can_push_i)
        else $error("result pushed into a full output stage");

    a_tick_enters_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && cmd_i == ptt_pkg::CMD_TICK) |=> (state_reg == S_TICK))
        else $error("tick did not start the slot sweep");

    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_req_o.we && mem_req_o.rd_en) |-> (mem_req_o.wr_addr != mem_req_o.rd_addr))
        else $error("read and write of the same slot in one cycle");

    a_sweep_push_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_o.valid && state_reg == S_TICK) |-> (!push_o.res.last && push_o.res.fired))
        else $error("mid-sweep word must be a non-final firing");

endmodule

`default_nettype wire

FILE: src/periodic_task_timer_table.sv
// Top level: stream ports, output register, slot store and sequencer.
// Command path: create, delete and commands rejected at decode go from decode to the
// response state; slot read-modify-write commands pass the command state first.
// Tick: one slot per cycle through the slot store read port while no stall holds
// the sweep, over all 16 slots; one command is in flight at a time.
// A stalled result side holds the sweep only when a second firing is found.
// Reset (aresetn low, synchronous) clears the active bits and the elapsed total
// at once; slot entries are written on create and used only while active, no clearing pass.
`default_nettype none

module periodic_task_timer_table (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [3:0] slot, [35:4] period_ms, [51:36] repeat_count, [52] clear_count,
    // [68:53] elapsed_ms, [71:69] zero
    input  wire logic [71:0] s_tdata,
    // [3:0] command
    input  wire logic [3:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [1:0] status, [5:2] result_slot, [6] fired, [7] finished, [8] present,
    // [24:9] repeat_value, [56:25] total_elapsed_ms, [63:57] zero
    output logic [63:0]      m_tdata,
    output logic             m_tlast
);

    ptt_pkg::mem_req_t    mem_req;
    ptt_pkg::slot_entry_t rd_data;
    ptt_pkg::push_t       push;
    logic                 can_push;
    logic                 m_valid_reg;
    ptt_pkg::result_t     m_res_reg;

    ptt_slot_mem u_mem (
        .aclk      (aclk),
        .req_i     (mem_req),
        .rd_data_o (rd_data)
    );

    ptt_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid_i (s_tvalid),
        .in_ready_o (s_tready),
        .cmd_i      (s_tuser),
        .slot_i     (s_tdata[3:0]),
        .period_i   (s_tdata[35:4]),
        .rpt_i      (s_tdata[51:36]),
        .clr_i      (s_tdata[52]),
        .elapsed_i  (s_tdata[68:53]),
        .mem_req_o  (mem_req),
        .rd_data_i  (rd_data),
        .can_push_i (can_push),
        .push_o     (push)
    );

    assign can_push = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (can_push) begin
            m_valid_reg <= push.valid;
        end
        if (can_push && push.valid) begin
            m_res_reg <= push.res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_res_reg.last;
    assign m_tdata  = {7'b0, m_res_reg.total, m_res_reg.repeat_value, m_res_reg.present,
                       m_res_reg.finished, m_res_reg.fired, m_res_reg.result_slot,
                       m_res_reg.status};

endmodule

`default_nettype wire
